// ===== hdl/spq_pkg.sv =====
// Types and constants shared by the sorted priority queue modules.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int FREQ_BITS   = 32;
	localparam int HANDLE_BITS = 9;
	localparam int OCC_BITS    = 9;
	localparam int STAT_BITS   = 2;
	localparam int DEPTH_DEF   = 256;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                   op;
		logic [FREQ_BITS-1:0]   in_freq;
		logic [HANDLE_BITS-1:0] in_handle;
	} spq_req_t;

	typedef struct packed {
		logic [FREQ_BITS-1:0]   out_freq;
		logic [HANDLE_BITS-1:0] out_handle;
		logic [STAT_BITS-1:0]   status;
		logic [OCC_BITS-1:0]    occupancy;
	} spq_rsp_t;

	typedef struct packed {
		logic [FREQ_BITS-1:0]   freq;
		logic [HANDLE_BITS-1:0] handle;
	} spq_entry_t;

	// Broadcast to every cell in the cycle of a transfer.
	typedef struct packed {
		logic       ins;
		logic       pop;
		spq_entry_t ent;
	} spq_cmd_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One slot of the sorted queue chain: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
(
	input  logic       clk,
	input  spq_cmd_t   cmd,
	input  logic       occ,
	input  logic       left_keep,
	input  spq_entry_t left_ent,
	input  spq_entry_t right_ent,
	output spq_entry_t ent,
	output logic       keep
);

	spq_entry_t ent_q;

	// Stay in place on insert when occupied and not above the new key.
	assign keep = occ & (ent_q.freq <= cmd.ent.freq);
	assign ent  = ent_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!keep) begin
				ent_q <= left_keep ? cmd.ent : left_ent;
			end
		end else if (cmd.pop) begin
			ent_q <= right_ent;
		end
	end

endmodule

// ===== hdl/sorted_priority_queue_core.sv =====
// Top level of the stable sorted priority queue: cell chain, count and result register.
`timescale 1ns / 1ps

// Channel  Signals                       Direction  Contents
// req      req_valid, req_ready, req     in         op, in_freq, in_handle
// rsp      rsp_valid, rsp_ready, rsp     out        out_freq, out_handle, status, occupancy
//
// Each cell compares its key with the incoming one and shifts locally, so
// one transfer per clock is taken while the result register is not stalled.
// The result is registered; it appears the cycle after the request transfer.
// Reset clears the entry count and the result valid; cell contents need none.
// A stalled result blocks new requests only while it is not being taken.

module sorted_priority_queue_core
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  spq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output spq_rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;
	spq_rsp_t         rsp_q;

	logic             xfer;
	logic             full;
	logic             empty;
	spq_cmd_t         cmd;
	logic [CNT_W-1:0] count_nxt;
	spq_rsp_t         rsp_nxt;
	logic [OCC_BITS+CNT_W-1:0] occ_wide;

	spq_entry_t       ents  [DEPTH];
	logic [DEPTH-1:0] keeps;
	logic [DEPTH-1:0] occs;

	// Accept a new request whenever the result register is free or draining.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign xfer      = req_valid && req_ready;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Drop inserts into a full queue and pops from an empty one before the chain sees them.
	always_comb begin
		cmd.ins        = xfer && (req.op == OP_INSERT) && !full;
		cmd.pop        = xfer && (req.op == OP_POP) && !empty;
		cmd.ent.freq   = req.in_freq;
		cmd.ent.handle = req.in_handle;
	end

	// Occupancy thermometer: cell i is live when it lies below the count.
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			spq_entry_t left_ent;
			spq_entry_t right_ent;
			logic       left_keep;

			assign occs[gi] = (CNT_W'(gi) < count_q);

			if (gi == 0) begin : g_head
				// Head takes the new entry whenever it does not stay.
				assign left_keep = 1'b1;
				assign left_ent  = cmd.ent;
			end else begin : g_mid
				assign left_keep = keeps[gi-1];
				assign left_ent  = ents[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_tail
				assign right_ent = ents[gi];
			end else begin : g_body
				assign right_ent = ents[gi+1];
			end

			spq_cell u_cell (
				.clk       (clk),
				.cmd       (cmd),
				.occ       (occs[gi]),
				.left_keep (left_keep),
				.left_ent  (left_ent),
				.right_ent (right_ent),
				.ent       (ents[gi]),
				.keep      (keeps[gi])
			);
		end
	endgenerate

	// Build the result of the request in transfer.
	always_comb begin
		count_nxt          = count_q;
		rsp_nxt.out_freq   = '0;
		rsp_nxt.out_handle = '0;
		rsp_nxt.status     = ST_OK;
		if (req.op == OP_INSERT) begin
			if (full) begin
				rsp_nxt.status = ST_FULL;
			end else begin
				count_nxt = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				rsp_nxt.status = ST_EMPTY;
			end else begin
				rsp_nxt.out_freq   = ents[0].freq;
				rsp_nxt.out_handle = ents[0].handle;
				count_nxt          = count_q - CNT_W'(1);
			end
		end
		occ_wide          = {{OCC_BITS{1'b0}}, count_nxt};
		rsp_nxt.occupancy = occ_wide[OCC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the payload until the next transfer replaces it.
	always_ff @(posedge clk) begin
		if (xfer) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps

module spq_checker
	import spq_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input spq_req_t req,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input spq_rsp_t rsp
);

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Every request transfer yields a result in the next cycle.
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("request transfer without result");

	// A pop on an empty queue returns no entry and leaves it empty.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY) |->
			(rsp.out_freq == '0) && (rsp.out_handle == '0) && (rsp.occupancy == '0))
		else $error("empty pop returned data");

	// An insert refused on a full queue carries no entry.
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |->
			(rsp.out_freq == '0) && (rsp.out_handle == '0))
		else $error("dropped insert returned data");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

// ===== dv/sorted_priority_queue_core_test.sv =====
// Self-checking testbench for the stable sorted priority queue core.
`timescale 1ns / 1ps

module sorted_priority_queue_core_test;
	import spq_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;
	localparam logic [HANDLE_BITS-1:0] HANDLE_MAX = '1;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	spq_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	spq_rsp_t rsp;

	// Mirror of the queue contents, head at index 0, and the results still owed.
	spq_entry_t queued_entries[$];
	spq_rsp_t   pending_rsp[$];

	// Sender burst control and receiver stall control.
	int tx_burst_left;
	int tx_gap_pct;
	int rx_stall_pct;
	int rx_hold;

	// Bookkeeping for the end-of-run summary.
	int mismatches;
	int rsp_checked;
	int cnt_insert;
	int cnt_pop;
	int cnt_full;
	int cnt_empty;
	int peak_occ;
	int max_req_stall;

	sorted_priority_queue_core #(
		.DEPTH(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#400_000;
		$display("FAIL");
		$finish;
	end

	// Work out the result of one request and advance the mirror queue.
	// Inserts land after every entry with an equal or lower key, so ties
	// leave in arrival order.
	function automatic spq_rsp_t apply_request(input spq_req_t r);
		spq_rsp_t   res;
		spq_entry_t ent;
		int         pos;
		res = '0;
		res.status = ST_OK;
		if (r.op == OP_INSERT) begin
			cnt_insert++;
			if (queued_entries.size() >= DEPTH) begin
				res.status = ST_FULL;
				cnt_full++;
			end else begin
				ent.freq = r.in_freq;
				ent.handle = r.in_handle;
				pos = 0;
				while (pos < queued_entries.size() && queued_entries[pos].freq <= r.in_freq)
					pos++;
				queued_entries.insert(pos, ent);
			end
		end else begin
			cnt_pop++;
			if (queued_entries.size() == 0) begin
				res.status = ST_EMPTY;
				cnt_empty++;
			end else begin
				ent = queued_entries.pop_front();
				res.out_freq = ent.freq;
				res.out_handle = ent.handle;
			end
		end
		res.occupancy = OCC_BITS'(queued_entries.size());
		if (queued_entries.size() > peak_occ)
			peak_occ = queued_entries.size();
		return res;
	endfunction

	// Key generator: wide random keys, narrow keys that collide often, and
	// keys at the edges of the range.
	function automatic logic [FREQ_BITS-1:0] pick_freq();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return FREQ_BITS'($urandom);
		else if (sel < 8)
			return FREQ_BITS'($urandom_range(0, 15));
		else if (sel == 8)
			return $urandom_range(0, 1) ? FREQ_MAX : FREQ_MAX - 1;
		else
			return FREQ_BITS'($urandom_range(0, 1));
	endfunction

	// Random handle for an insert.
	function automatic logic [HANDLE_BITS-1:0] pick_handle();
		return HANDLE_BITS'($urandom_range(0, HANDLE_MAX));
	endfunction

	// Offer one request at the falling edge and hold it until the transfer.
	// Gaps go in between bursts of random length.
	task automatic send_req(input logic op, input logic [FREQ_BITS-1:0] freq,
			input logic [HANDLE_BITS-1:0] handle);
		spq_req_t item;
		int       stall;
		item.op = op;
		item.in_freq = freq;
		item.in_handle = handle;
		stall = 0;
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 99) < tx_gap_pct) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) begin
			stall++;
			@(posedge clk);
		end
		if (stall > max_req_stall)
			max_req_stall = stall;
		pending_rsp.push_back(apply_request(item));
		tx_burst_left--;
		@(negedge clk);
	endtask

	// Send a pop with junk in the unused key and handle fields.
	task automatic send_pop_junk();
		send_req(OP_POP, FREQ_BITS'($urandom), HANDLE_BITS'($urandom));
	endtask

	// Drop valid and wait until every owed result has come back.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: alternate runs of ready and stall, plus a long hold-off when asked.
	initial begin
		logic run_ready;
		int   run_left;
		rsp_ready = 1'b0;
		run_ready = 1'b1;
		run_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rsp_ready <= 1'b0;
				rx_hold--;
			end else begin
				if (run_left == 0) begin
					run_ready = ($urandom_range(0, 99) >= rx_stall_pct);
					run_left = run_ready ? $urandom_range(1, 10) : $urandom_range(1, 6);
				end
				rsp_ready <= run_ready;
				run_left--;
			end
		end
	end

	// Check every result transfer against the oldest owed result.
	always @(posedge clk) begin
		spq_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_checked++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t: unexpected result freq=%h handle=%h status=%0d occ=%0d",
						$realtime, rsp.out_freq, rsp.out_handle, rsp.status, rsp.occupancy);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.out_freq !== want.out_freq || rsp.out_handle !== want.out_handle ||
						rsp.status !== want.status || rsp.occupancy !== want.occupancy) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%t: result mismatch: freq exp %h got %h, handle exp %h got %h,",
							" status exp %0d got %0d, occ exp %0d got %0d"}, $realtime,
							want.out_freq, rsp.out_freq, want.out_handle, rsp.out_handle,
							want.status, rsp.status, want.occupancy, rsp.occupancy);
				end
			end
		end
	end

	// Edge keys and handles, ties at both ends, pops past empty.
	task automatic test_directed();
		int k;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		send_req(OP_POP, FREQ_MAX, HANDLE_MAX);
		send_req(OP_INSERT, '0, '0);
		send_req(OP_INSERT, FREQ_MAX, HANDLE_MAX);
		send_req(OP_INSERT, 32'h5555_5555, 9'h155);
		send_req(OP_INSERT, 32'hAAAA_AAAA, 9'h0AA);
		send_req(OP_INSERT, '0, 9'd7);
		send_req(OP_INSERT, FREQ_MAX, 9'd300);
		send_req(OP_INSERT, 32'h5555_5555, 9'h001);
		send_req(OP_INSERT, 32'h0000_0001, HANDLE_MAX);
		for (k = 0; k < 9; k++)
			send_req(OP_POP, '0, '0);
		send_req(OP_INSERT, 32'h8000_0000, 9'h100);
		send_req(OP_POP, '0, '0);
		send_req(OP_POP, '0, '0);
		drain_results();
	endtask

	// Fill to capacity with colliding keys, push past full, then drain past empty.
	task automatic test_fill_to_full();
		int k;
		tx_gap_pct = 30;
		rx_stall_pct = 25;
		while (queued_entries.size() < DEPTH) begin
			if ($urandom_range(0, 99) < 2)
				send_pop_junk();
			else
				send_req(OP_INSERT, pick_freq(), pick_handle());
		end
		for (k = 0; k < 3; k++)
			send_req(OP_INSERT, pick_freq(), pick_handle());
		send_req(OP_POP, '0, '0);
		send_req(OP_INSERT, FREQ_MAX, HANDLE_MAX);
		send_req(OP_INSERT, '0, '0);
		while (queued_entries.size() > 0) begin
			if ($urandom_range(0, 99) < 2)
				send_req(OP_INSERT, pick_freq(), pick_handle());
			else
				send_pop_junk();
		end
		send_req(OP_POP, '0, '0);
		drain_results();
	endtask

	// Phases with their own insert/pop mix and idling, some with no idling.
	task automatic test_random_mix();
		int phase;
		int k;
		int insert_pct;
		for (phase = 0; phase < 3; phase++) begin
			insert_pct = $urandom_range(20, 85);
			tx_gap_pct = (phase % 4 == 0) ? 0 : $urandom_range(10, 70);
			rx_stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
			for (k = 0; k < 10; k++) begin
				if ($urandom_range(0, 99) < insert_pct)
					send_req(OP_INSERT, pick_freq(), pick_handle());
				else
					send_pop_junk();
			end
		end
		drain_results();
	endtask

	// Hold the receiver off for a long stretch while requests keep coming,
	// so the result register backs up and the request side stalls.
	task automatic test_backpressure();
		int k;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		rx_hold = 150;
		for (k = 0; k < 12; k++) begin
			if (k % 3 == 2)
				send_req(OP_POP, '0, '0);
			else
				send_req(OP_INSERT, pick_freq(), pick_handle());
		end
		drain_results();
		while (queued_entries.size() > 0)
			send_req(OP_POP, '0, '0);
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		tx_burst_left = 0;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		rx_hold = 0;
		mismatches = 0;
		rsp_checked = 0;
		cnt_insert = 0;
		cnt_pop = 0;
		cnt_full = 0;
		cnt_empty = 0;
		peak_occ = 0;
		max_req_stall = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_fill_to_full();
		test_random_mix();
		test_backpressure();

		$display("Covered %0d inserts (%0d refused when full) and %0d pops (%0d on empty),",
			cnt_insert, cnt_full, cnt_pop, cnt_empty);
		$display("peak occupancy %0d; checked %0d results, %0d mismatches, longest stall %0d.",
			peak_occ, rsp_checked, mismatches, max_req_stall);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
